FILE: rtl/core/bounded_set_table_top_macros.svh
// Assertion macros for the bounded set table checker.
`ifndef BOUNDED_SET_TABLE_TOP_MACROS_SVH
`define BOUNDED_SET_TABLE_TOP_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define BST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define BST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/core/bst_pkg.sv
// Shared types and constants for the bounded set table.
package bst_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned ElemW    = 16;
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned LogCap   = $clog2(Capacity);
  localparam int unsigned OpW      = 2;
  localparam int unsigned OutCntW  = 7;

  typedef enum logic [OpW-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_RSVD   = 2'd3
  } op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

FILE: rtl/core/bst_ctrl.sv
// Controller: sequences accept and execute of one word.
module bst_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  output bst_pkg::cmd_t     cmd_o
);

  bst_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bst_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bst_pkg::ST_IDLE: begin
        if (start_i) state_d = bst_pkg::ST_EXEC;
      end
      bst_pkg::ST_EXEC: state_d = bst_pkg::ST_IDLE;
      default:          state_d = bst_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b0;
    unique case (state_q)
      bst_pkg::ST_IDLE: cmd_o.load = start_i;
      bst_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        busy_o     = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/bst_dpath.sv
// Datapath: row of compare-and-shift cells, count and result registers.
module bst_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bst_pkg::cmd_t                 cmd_i,
  input  logic [bst_pkg::OpW-1:0]       operation_i,
  input  logic [bst_pkg::ElemW-1:0]     element_i,
  output logic                          strobe_o,
  output logic                          was_present_o,
  output logic [bst_pkg::OutCntW-1:0]   element_count_o,
  output logic                          set_full_o,
  output logic                          set_empty_o,
  output logic                          insert_dropped_o
);

  bst_pkg::op_e                      op_q;
  logic [bst_pkg::ElemW-1:0]         elem_q;
  logic [bst_pkg::ElemW-1:0]         cells_q [bst_pkg::Capacity];
  logic [bst_pkg::ElemW-1:0]         cells_d [bst_pkg::Capacity];
  logic [bst_pkg::CntW-1:0]          count_q, count_d;
  logic [bst_pkg::Capacity-1:0]      match_v, shift_v;
  logic                              present, do_ins, do_del, dropped, full_now;

  logic                              strobe_q, present_q, full_q, empty_q, dropped_q;
  logic [bst_pkg::OutCntW-1:0]       cnt_out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= bst_pkg::op_e'(operation_i);
      elem_q <= element_i;
    end
  end

  always_comb begin
    for (int i = 0; i < bst_pkg::Capacity; i++) begin
      match_v[i] = (count_q > bst_pkg::CntW'(i)) && (cells_q[i] == elem_q);
    end
    present = |match_v;
    // prefix OR marks the matching cell and every cell above it
    shift_v = match_v;
    for (int k = 0; k < bst_pkg::LogCap; k++) begin
      shift_v = shift_v | (shift_v << (1 << k));
    end
  end

  assign full_now = (count_q == bst_pkg::CntW'(bst_pkg::Capacity));

  always_comb begin
    do_ins  = 1'b0;
    do_del  = 1'b0;
    dropped = 1'b0;
    unique case (op_q)
      bst_pkg::OP_INSERT: begin
        do_ins  = !present && !full_now;
        dropped = !present && full_now;
      end
      bst_pkg::OP_DELETE: do_del = present;
      bst_pkg::OP_QUERY,
      bst_pkg::OP_RSVD:   ;
      default:            ;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (do_ins) count_d = count_q + bst_pkg::CntW'(1);
    else if (do_del) count_d = count_q - bst_pkg::CntW'(1);
  end

  always_comb begin
    for (int i = 0; i < bst_pkg::Capacity; i++) begin
      cells_d[i] = cells_q[i];
      if (do_del && shift_v[i] && (i < bst_pkg::Capacity - 1)) begin
        cells_d[i] = cells_q[(i + 1) % bst_pkg::Capacity];
      end else if (do_ins && (count_q == bst_pkg::CntW'(i))) begin
        cells_d[i] = elem_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      cells_q   <= cells_d;
      present_q <= present;
      cnt_out_q <= bst_pkg::OutCntW'(count_d);
      full_q    <= (count_d == bst_pkg::CntW'(bst_pkg::Capacity));
      empty_q   <= (count_d == '0);
      dropped_q <= dropped;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.exec;
      if (cmd_i.exec) count_q <= count_d;
    end
  end

  assign strobe_o         = strobe_q;
  assign was_present_o    = present_q;
  assign element_count_o  = cnt_out_q;
  assign set_full_o       = full_q;
  assign set_empty_o      = empty_q;
  assign insert_dropped_o = dropped_q;

endmodule

FILE: rtl/core/bounded_set_table_top.sv
// Top level of the bounded set table.
// An accepted word is registered, then executed; its results and the strobe are registered at the end of execute.
// A new word is accepted only while idle, never while busy_o is high; busy_o is high for the single execute cycle.
// All member compares and the delete shift happen in that execute cycle across 64 cells.
// Reset: asynchronous, active low; clears the count and the FSM, the cells stay unknown.
// The result strobe lasts one cycle and cannot be stalled by the receiver.
module bounded_set_table_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [bst_pkg::OpW-1:0]       operation_i,
  input  logic [bst_pkg::ElemW-1:0]     element_i,
  output logic                          strobe_o,
  output logic                          was_present_o,
  output logic [bst_pkg::OutCntW-1:0]   element_count_o,
  output logic                          set_full_o,
  output logic                          set_empty_o,
  output logic                          insert_dropped_o
);

  bst_pkg::cmd_t cmd;

  bst_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .cmd_o   (cmd)
  );

  bst_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .operation_i      (operation_i),
    .element_i        (element_i),
    .strobe_o         (strobe_o),
    .was_present_o    (was_present_o),
    .element_count_o  (element_count_o),
    .set_full_o       (set_full_o),
    .set_empty_o      (set_empty_o),
    .insert_dropped_o (insert_dropped_o)
  );

endmodule

FILE: rtl/core/bst_chk.sv
// Port-level checker for the bounded set table, bound to the top level.
`include "bounded_set_table_top_macros.svh"

module bst_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input logic [bst_pkg::OpW-1:0]       operation_i,
  input logic [bst_pkg::ElemW-1:0]     element_i,
  input logic                          strobe_o,
  input logic                          was_present_o,
  input logic [bst_pkg::OutCntW-1:0]   element_count_o,
  input logic                          set_full_o,
  input logic                          set_empty_o,
  input logic                          insert_dropped_o
);

  `BST_ASSERT(a_accept_busy, (start_i && !busy_o) |=> busy_o, "accept did not raise busy")
  `BST_ASSERT(a_busy_result, busy_o |=> (strobe_o && !busy_o), "no result after execute")
  `BST_ASSERT(a_strobe_single, strobe_o |=> !strobe_o, "result strobe longer than a cycle")
  `BST_ASSERT(a_empty_count, (strobe_o && set_empty_o) |-> (element_count_o == '0),
              "empty flag with nonzero count")
  `BST_ASSERT_ALWAYS(a_full_empty, !(strobe_o && set_full_o && set_empty_o),
                     "set both full and empty")

endmodule

bind bounded_set_table_top bst_chk u_bst_chk (.*);

FILE: tb/sv/testbench.sv
// Self-checking testbench for the bounded set table: directed and random command words against a set predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 200000;
  localparam int TotalWords = 1570;
  localparam int SettleCycles = 6;

  typedef struct packed {
    logic                        was_present;
    logic [bst_pkg::OutCntW-1:0] cnt;
    logic                        full;
    logic                        empty;
    logic                        dropped;
  } set_result_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start_i;
  logic                        busy_o;
  bst_pkg::op_e                operation_i;
  logic [bst_pkg::ElemW-1:0]   element_i;
  logic                        strobe_o;
  logic                        was_present_o;
  logic [bst_pkg::OutCntW-1:0] element_count_o;
  logic                        set_full_o;
  logic                        set_empty_o;
  logic                        insert_dropped_o;

  logic [bst_pkg::ElemW-1:0] set_members[$];
  set_result_t               pending_results[$];
  logic [bst_pkg::ElemW-1:0] value_pool[64];

  int error_count;
  int cycle_count;
  int words_sent;
  int results_checked;
  int full_seen;
  int dropped_seen;
  int burst_left;

  bounded_set_table_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .operation_i     (operation_i),
    .element_i       (element_i),
    .strobe_o        (strobe_o),
    .was_present_o   (was_present_o),
    .element_count_o (element_count_o),
    .set_full_o      (set_full_o),
    .set_empty_o     (set_empty_o),
    .insert_dropped_o(insert_dropped_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    error_count++;
  endtask

  // Applies one word to the predicted set and returns the result it should produce.
  function automatic set_result_t apply_set_op(bst_pkg::op_e op,
                                               logic [bst_pkg::ElemW-1:0] elem);
    int          slot;
    set_result_t r;
    slot = -1;
    foreach (set_members[i]) begin
      if (slot < 0 && set_members[i] == elem) slot = i;
    end
    r = '0;
    r.was_present = (slot >= 0);
    case (op)
      bst_pkg::OP_INSERT: begin
        if (slot < 0) begin
          if (set_members.size() >= bst_pkg::Capacity) r.dropped = 1'b1;
          else set_members.push_back(elem);
        end
      end
      bst_pkg::OP_DELETE: begin
        if (slot >= 0) set_members.delete(slot);
      end
      default: ;
    endcase
    r.cnt   = bst_pkg::OutCntW'(set_members.size());
    r.full  = (set_members.size() == bst_pkg::Capacity);
    r.empty = (set_members.size() == 0);
    return r;
  endfunction

  // Result check first, then prediction of a word accepted at this edge.
  always @(posedge clk_i) begin
    set_result_t want;
    if (rst_ni) begin
      if (strobe_o) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result strobe with no word pending");
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (was_present_o !== want.was_present)
            report_mismatch($sformatf("was_present got %b want %b", was_present_o,
                                      want.was_present));
          if (element_count_o !== want.cnt)
            report_mismatch($sformatf("element_count got %0d want %0d", element_count_o,
                                      want.cnt));
          if (set_full_o !== want.full)
            report_mismatch($sformatf("set_full got %b want %b", set_full_o, want.full));
          if (set_empty_o !== want.empty)
            report_mismatch($sformatf("set_empty got %b want %b", set_empty_o, want.empty));
          if (insert_dropped_o !== want.dropped)
            report_mismatch($sformatf("insert_dropped got %b want %b", insert_dropped_o,
                                      want.dropped));
          if (want.full) full_seen++;
          if (want.dropped) dropped_seen++;
        end
      end
      if (start_i && !busy_o) begin
        pending_results.push_back(apply_set_op(bst_pkg::op_e'(operation_i), element_i));
      end
    end
  end

  // Sends one word; bursts of random length with random gaps between them.
  task automatic send_word(bst_pkg::op_e op, logic [bst_pkg::ElemW-1:0] elem,
                           bit from_members);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        @(negedge clk_i);
        start_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    @(negedge clk_i);
    if (from_members && set_members.size() > 0)
      elem = set_members[$urandom_range(0, set_members.size() - 1)];
    start_i     <= 1'b1;
    operation_i <= op;
    element_i   <= elem;
    do @(posedge clk_i); while (busy_o);
    burst_left--;
    words_sent++;
  endtask

  task automatic wait_all_results();
    @(negedge clk_i);
    start_i <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic bst_pkg::op_e pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return bst_pkg::OP_INSERT;
    if (r < 70) return bst_pkg::OP_DELETE;
    if (r < 95) return bst_pkg::OP_QUERY;
    return bst_pkg::OP_RSVD;
  endfunction

  task automatic test_directed_corners();
    send_word(bst_pkg::OP_QUERY,  16'h0000, 1'b0);
    send_word(bst_pkg::OP_DELETE, 16'h1234, 1'b0);
    send_word(bst_pkg::OP_RSVD,   16'hFFFF, 1'b0);
    send_word(bst_pkg::OP_INSERT, 16'h0000, 1'b0);
    send_word(bst_pkg::OP_INSERT, 16'hFFFF, 1'b0);
    send_word(bst_pkg::OP_INSERT, 16'h0000, 1'b0);
    send_word(bst_pkg::OP_QUERY,  16'hFFFF, 1'b0);
    send_word(bst_pkg::OP_QUERY,  16'h5555, 1'b0);
    send_word(bst_pkg::OP_INSERT, 16'hAAAA, 1'b0);
    send_word(bst_pkg::OP_INSERT, 16'h5555, 1'b0);
    send_word(bst_pkg::OP_DELETE, 16'h0000, 1'b0);
    send_word(bst_pkg::OP_QUERY,  16'hFFFF, 1'b0);
    send_word(bst_pkg::OP_QUERY,  16'hAAAA, 1'b0);
    send_word(bst_pkg::OP_DELETE, 16'h5555, 1'b0);
    send_word(bst_pkg::OP_DELETE, 16'h5555, 1'b0);
    send_word(bst_pkg::OP_RSVD,   16'hAAAA, 1'b0);
    send_word(bst_pkg::OP_DELETE, 16'hFFFF, 1'b0);
    send_word(bst_pkg::OP_DELETE, 16'hAAAA, 1'b0);
    send_word(bst_pkg::OP_INSERT, 16'h8001, 1'b0);
    send_word(bst_pkg::OP_DELETE, 16'h8001, 1'b0);
    send_word(bst_pkg::OP_QUERY,  16'h8001, 1'b0);
  endtask

  // Fills the set, pushes past capacity, then empties it in random order.
  task automatic test_full_set();
    int guard;
    guard = 0;
    while (set_members.size() < bst_pkg::Capacity && guard < 4 * bst_pkg::Capacity) begin
      send_word(bst_pkg::OP_INSERT, bst_pkg::ElemW'($urandom()), 1'b0);
      guard++;
    end
    repeat ($urandom_range(2, 5)) begin
      send_word(bst_pkg::OP_INSERT, bst_pkg::ElemW'($urandom()), 1'b0);
      send_word(bst_pkg::OP_INSERT, 16'h0, 1'b1);
      send_word(bst_pkg::OP_QUERY, 16'h0, 1'b1);
    end
    guard = 0;
    while (set_members.size() > 0 && guard < 4 * bst_pkg::Capacity) begin
      send_word(bst_pkg::OP_DELETE, 16'h0, 1'b1);
      if ($urandom_range(0, 7) == 0)
        send_word(bst_pkg::OP_DELETE, bst_pkg::ElemW'($urandom()), 1'b0);
      guard++;
    end
  endtask

  task automatic test_random_mix();
    int mode;
    int r;
    logic [bst_pkg::ElemW-1:0] elem;
    bit from_members;
    while (words_sent < TotalWords) begin
      foreach (value_pool[i]) value_pool[i] = bst_pkg::ElemW'($urandom());
      mode = $urandom_range(0, 9);
      if (mode < 2) begin
        test_full_set();
      end else begin
        repeat ($urandom_range(20, 60)) begin
          r = $urandom_range(0, 99);
          from_members = (r < 50);
          elem = (r < 85) ? value_pool[$urandom_range(0, 63)] : bst_pkg::ElemW'($urandom());
          send_word(pick_op(), elem, from_members);
        end
        if (mode == 2) wait_all_results();
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    operation_i = bst_pkg::OP_INSERT;
    element_i   = '0;
    error_count = 0;
    cycle_count = 0;
    words_sent  = 0;
    burst_left  = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_corners();
    wait_all_results();
    test_full_set();
    wait_all_results();
    test_random_mix();
    wait_all_results();

    $display("%0d words sent, %0d results checked, %0d left unanswered", words_sent,
             results_checked, pending_results.size());
    $display("set reported full %0d times, %0d inserts refused", full_seen, dropped_seen);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/bst_pkg.sv
rtl/core/bst_ctrl.sv
rtl/core/bst_dpath.sv
rtl/core/bounded_set_table_top.sv
rtl/core/bst_chk.sv
tb/sv/testbench.sv
